FILE: sv/ddp_pkg.sv
// package: shared types and constants for the depth pixel deprojection block
`timescale 1ns / 1ps
package ddp_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] ImageWidthRst = 16'd640;
  localparam logic [23:0] DepthScaleRst = 24'd16777;
  localparam logic [23:0] RangeMinRst   = 24'd13107;
  localparam logic [23:0] RangeMaxRst   = 24'd262144;
  localparam logic [23:0] FocalXRst     = 24'd98304;
  localparam logic [23:0] FocalYRst     = 24'd98304;
  localparam logic [23:0] CenterXRst    = 24'd81920;
  localparam logic [23:0] CenterYRst    = 24'd61440;

  localparam int unsigned RowStepDef = 1;
  localparam int unsigned ColStepDef = 1;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_Z_SCALE     = 3'd1,
    REG_Z_MIN       = 3'd2,
    REG_Z_MAX       = 3'd3,
    REG_FOCAL_X     = 3'd4,
    REG_FOCAL_Y     = 3'd5,
    REG_CENTER_X    = 3'd6,
    REG_CENTER_Y    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] image_width;
    logic [23:0] z_scale;
    logic [23:0] z_min;
    logic [23:0] z_max;
    logic [23:0] focal_x;
    logic [23:0] focal_y;
    logic [23:0] center_x;
    logic [23:0] center_y;
  } cfg_t;

  // one kept pixel handed from front to back
  typedef struct packed {
    logic        pt_valid;
    logic [15:0] col;
    logic [15:0] row;
    logic [23:0] z;
  } pt_t;

endpackage

FILE: sv/ddp_if.sv
// interfaces: pixel input channel and point output channel
`timescale 1ns / 1ps
interface ddp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_raw;
  logic        frame_start;
  modport source (output valid, depth_raw, frame_start, input ready);
  modport sink (input valid, depth_raw, frame_start, output ready);
endinterface

interface ddp_out_if;
  logic               valid;
  logic               ready;
  logic               point_valid;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic        [23:0] z_pos;
  modport source (output valid, point_valid, x_pos, y_pos, z_pos, input ready);
  modport sink (input valid, point_valid, x_pos, y_pos, z_pos, output ready);
endinterface

FILE: sv/ddp_front.sv
// front: pixel counters, decimation grid, depth scaling and range check
`timescale 1ns / 1ps
module ddp_front import ddp_pkg::*; #(
  parameter int unsigned ROW_DECIM = RowStepDef,
  parameter int unsigned COL_DECIM = ColStepDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] depth_raw_i,
  input  logic        frame_start_i,
  input  logic        full_i,
  output logic        push_o,
  output pt_t         pt_o
);

  localparam int unsigned RW = (ROW_DECIM > 1) ? $clog2(ROW_DECIM) : 1;
  localparam int unsigned CW = (COL_DECIM > 1) ? $clog2(COL_DECIM) : 1;

  logic [15:0] col_q, col_d, row_q, row_d, u, v;
  logic [RW-1:0] rph_q, rph_d, rph;
  logic [CW-1:0] cph_q, cph_d, cph;
  logic [16:0] nxt, lim;
  logic [39:0] prod;
  logic [31:0] zw;
  logic accept, keep, ok;

  assign in_ready_o = !full_i;
  assign accept = in_valid_i && !full_i;

  always_comb begin
    u   = frame_start_i ? '0 : col_q;
    v   = frame_start_i ? '0 : row_q;
    rph = frame_start_i ? '0 : rph_q;
    cph = frame_start_i ? '0 : cph_q;
    keep = (rph == '0) && (cph == '0);
    nxt = {1'b0, u} + 17'd1;
    lim = {(cfg_i.image_width == '0), cfg_i.image_width};
    col_d = col_q;
    row_d = row_q;
    rph_d = rph_q;
    cph_d = cph_q;
    if (accept) begin
      if (nxt >= lim) begin
        col_d = '0;
        cph_d = '0;
        row_d = v + 16'd1;
        if (v == 16'hFFFF || rph == RW'(ROW_DECIM - 1)) rph_d = '0;
        else rph_d = rph + RW'(1);
      end else begin
        col_d = nxt[15:0];
        row_d = v;
        rph_d = rph;
        cph_d = (cph == CW'(COL_DECIM - 1)) ? '0 : cph + CW'(1);
      end
    end
  end

  assign prod = 40'(depth_raw_i) * 40'(cfg_i.z_scale);
  assign zw   = prod[39:8];
  assign ok   = (depth_raw_i != '0) && (zw >= 32'(cfg_i.z_min))
             && (zw <= 32'(cfg_i.z_max)) && (cfg_i.focal_x != '0)
             && (cfg_i.focal_y != '0);

  assign push_o      = accept && keep;
  assign pt_o.pt_valid = ok;
  assign pt_o.col    = u;
  assign pt_o.row    = v;
  assign pt_o.z      = ok ? zw[23:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rph_q <= '0;
      cph_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      rph_q <= rph_d;
      cph_q <= cph_d;
    end
  end

endmodule

FILE: sv/ddp_queue.sv
// queue: short fifo of kept pixels between front and back
`timescale 1ns / 1ps
module ddp_queue import ddp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pt_t  pt_i,
  input  logic pop_i,
  output pt_t  pt_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned NW = $clog2(QueueDepth + 1);

  pt_t mem_q [QueueDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;

  assign full_o  = (cnt_q == NW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign pt_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= pt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QueueDepth - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i) rd_q <= (rd_q == PW'(QueueDepth - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + NW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - NW'(1);
    end
  end

endmodule

FILE: sv/ddp_back.sv
// back: offset times depth, restoring divide by focal length, saturation
`timescale 1ns / 1ps
module ddp_back import ddp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               empty_i,
  input  pt_t                pt_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               point_valid_o,
  output logic signed [31:0] x_pos_o,
  output logic signed [31:0] y_pos_o,
  output logic        [23:0] z_pos_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SAT  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  pt_t pt_q;
  logic axis_q, neg_q;
  logic [47:0] quo_q;
  logic [23:0] rem_q;
  logic [5:0] cnt_q;
  logic [31:0] xr_q, yr_q;

  logic [23:0] pos, ctr, mag, foc;
  logic [24:0] trial;
  logic [31:0] mag32, res;
  logic big;

  assign pos   = {axis_q ? pt_q.row : pt_q.col, 8'd0};
  assign ctr   = axis_q ? cfg_i.center_y : cfg_i.center_x;
  assign foc   = axis_q ? cfg_i.focal_y : cfg_i.focal_x;
  assign mag   = (ctr > pos) ? ctr - pos : pos - ctr;
  assign trial = {rem_q, quo_q[47]};

  always_comb begin
    if (neg_q) begin
      big   = (|quo_q[47:32]) || (quo_q[31] && (|quo_q[30:0]));
      mag32 = big ? 32'h8000_0000 : quo_q[31:0];
      res   = 32'd0 - mag32;
    end else begin
      big   = (|quo_q[47:32]) || quo_q[31];
      mag32 = quo_q[31:0];
      res   = big ? 32'h7FFF_FFFF : quo_q[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      S_IDLE: if (!empty_i) begin
        pop_o   = 1'b1;
        state_d = pt_i.pt_valid ? S_MUL : S_OUT;
      end
      S_MUL: state_d = S_DIV;
      S_DIV: if (cnt_q == 6'd47) state_d = S_SAT;
      S_SAT: state_d = axis_q ? S_OUT : S_MUL;
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        pt_q   <= pt_i;
        axis_q <= 1'b0;
        xr_q   <= '0;
        yr_q   <= '0;
      end
      S_MUL: begin
        neg_q <= ctr > pos;
        quo_q <= 48'(mag) * 48'(pt_q.z);
        rem_q <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        cnt_q <= cnt_q + 6'd1;
        if (trial >= {1'b0, foc}) begin
          rem_q <= 24'(trial - {1'b0, foc});
          quo_q <= {quo_q[46:0], 1'b1};
        end else begin
          rem_q <= trial[23:0];
          quo_q <= {quo_q[46:0], 1'b0};
        end
      end
      S_SAT: begin
        if (axis_q) yr_q <= res;
        else xr_q <= res;
        axis_q <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign out_valid_o   = (state_q == S_OUT);
  assign point_valid_o = pt_q.pt_valid;
  assign x_pos_o       = xr_q;
  assign y_pos_o       = yr_q;
  assign z_pos_o       = pt_q.z;

endmodule

FILE: sv/depth_pixel_deprojection.sv
// top level: pinhole deprojection of a raw depth pixel stream
//
//   channel  dir  handshake    word
//   in_i     in   valid/ready  depth_raw, frame_start
//   out_o    out  valid/ready  point_valid, x_pos, y_pos, z_pos
//   cfg      in   cfg_we_i     cfg_idx_i, cfg_data_i
//
// the front takes one pixel per cycle while the two-entry queue has room
// a valid point in the back goes, per axis, through one multiply,
// 48 steps of the restoring divider and one saturation step
// an invalid or out-of-range point goes from idle straight to output in the back
// reset clears counters, queue and state and loads the default registers
// out_o stalls hold the back; the front then stalls once the queue is full
`timescale 1ns / 1ps
module depth_pixel_deprojection import ddp_pkg::*; #(
  parameter int unsigned ROW_DECIM = RowStepDef,
  parameter int unsigned COL_DECIM = ColStepDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  ddp_in_if.sink      in_i,
  ddp_out_if.source   out_o
);

  cfg_t cfg_q;
  pt_t  f_pt, q_pt;
  logic push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width <= ImageWidthRst;
      cfg_q.z_scale     <= DepthScaleRst;
      cfg_q.z_min       <= RangeMinRst;
      cfg_q.z_max       <= RangeMaxRst;
      cfg_q.focal_x     <= FocalXRst;
      cfg_q.focal_y     <= FocalYRst;
      cfg_q.center_x    <= CenterXRst;
      cfg_q.center_y    <= CenterYRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data_i[15:0];
        REG_Z_SCALE:     cfg_q.z_scale     <= cfg_data_i;
        REG_Z_MIN:       cfg_q.z_min       <= cfg_data_i;
        REG_Z_MAX:       cfg_q.z_max       <= cfg_data_i;
        REG_FOCAL_X:     cfg_q.focal_x     <= cfg_data_i;
        REG_FOCAL_Y:     cfg_q.focal_y     <= cfg_data_i;
        REG_CENTER_X:    cfg_q.center_x    <= cfg_data_i;
        REG_CENTER_Y:    cfg_q.center_y    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ddp_front #(.ROW_DECIM(ROW_DECIM), .COL_DECIM(COL_DECIM)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .depth_raw_i(in_i.depth_raw), .frame_start_i(in_i.frame_start),
    .full_i(full), .push_o(push), .pt_o(f_pt)
  );

  ddp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .pt_i(f_pt), .pop_i(pop),
    .pt_o(q_pt), .full_o(full), .empty_o(empty)
  );

  ddp_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .pt_i(q_pt), .pop_o(pop),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .point_valid_o(out_o.point_valid), .x_pos_o(out_o.x_pos),
    .y_pos_o(out_o.y_pos), .z_pos_o(out_o.z_pos)
  );

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.point_valid |->
      out_o.x_pos == 0 && out_o.y_pos == 0 && out_o.z_pos == 0)
    else $error("invalid point with nonzero coordinates");

  a_z_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.point_valid |->
      out_o.z_pos >= cfg_q.z_min && out_o.z_pos <= cfg_q.z_max)
    else $error("valid point depth outside range window");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue pop while empty");

endmodule
